// File: sv/pngrgb_pkg.sv
// ----------------------------------------------------------------------------
// pngrgb_pkg
// Shared constants and codes for the PNG pixel to RGB565 and alpha unit.
// ----------------------------------------------------------------------------
package pngrgb_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int MAX_WIDTH     = 1024;
    localparam int MAX_HEIGHT    = 1024;

    localparam int INDEX_W   = 8;
    localparam int COLUMN_W  = 10;
    localparam int WIDTH_W   = 11;
    localparam int ROW_W     = 10;
    localparam int ADDRESS_W = 20;
    localparam int TLEN_W    = 9;
    localparam int CFG_W     = 11;

    localparam logic [1:0] FUNC_LOAD_PALETTE = 2'd0;
    localparam logic [1:0] FUNC_LOAD_TRANS   = 2'd1;
    localparam logic [1:0] FUNC_PIXEL        = 2'd2;
    localparam logic [1:0] FUNC_START_IMAGE  = 2'd3;

    localparam logic [1:0] CFG_PIXEL_KIND   = 2'd0;
    localparam logic [1:0] CFG_TRANS_MAP    = 2'd1;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_TRANS_LENGTH = 2'd3;

    localparam logic [2:0] KIND_COLOR = 3'h2;
    localparam logic [2:0] KIND_ALPHA = 3'h4;

    localparam logic [7:0] OPAQUE = 8'hFF;

    typedef logic [23:0] palette_entry_t;

endpackage

// File: sv/png_pixel_to_rgb565_alpha_unit.sv
// ----------------------------------------------------------------------------
// png_pixel_to_rgb565_alpha_unit
// Converts decoded PNG pixels to RGB565 with an 8-bit alpha and an address.
// ----------------------------------------------------------------------------
// The unit takes one request per clock while req_stall is low. Each pixel
// request returns one result via the second stage and the output register.
// Load and start image requests return nothing. The palette and transparency
// tables sit in synchronous memories that are read as the request is taken.
// A second stage forms the colour, alpha, address and row end, and an output
// register follows it. A result that waits to be taken holds up the input only
// once a further pixel request has reached the second stage.
module png_pixel_to_rgb565_alpha_unit
    import pngrgb_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic [1:0]           func,
    input  logic [INDEX_W-1:0]   entry_index,
    input  logic [7:0]           byte0,
    input  logic [7:0]           byte1,
    input  logic [7:0]           byte2,
    input  logic [7:0]           byte3,
    input  logic [ROW_W-1:0]     row,
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [ADDRESS_W-1:0] pixel_address,
    output logic [15:0]          pixel_rgb565,
    output logic [7:0]           pixel_alpha,
    output logic                 alpha_seen,
    output logic                 row_end,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    palette_entry_t palette_mem [PALETTE_DEPTH];
    logic [7:0]     trans_mem   [PALETTE_DEPTH];

    logic [2:0]          pixel_kind_reg;
    logic                trans_map_reg;
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [TLEN_W-1:0]   trans_length_reg;

    logic                s1_valid_reg;
    logic [1:0]          s1_func_reg;
    logic [7:0]          s1_byte0_reg;
    logic [7:0]          s1_byte1_reg;
    logic [7:0]          s1_byte2_reg;
    logic [7:0]          s1_byte3_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    palette_entry_t      pal_data_reg;
    logic [7:0]          trans_data_reg;

    logic [COLUMN_W-1:0] column_count_reg;
    logic [COLUMN_W-1:0] column_count_next;
    logic                alpha_flag_reg;
    logic                alpha_flag_next;

    logic                res_valid_reg;
    logic [ADDRESS_W-1:0] address_reg;
    logic [15:0]         rgb_reg;
    logic [7:0]          alpha_reg;
    logic                seen_reg;
    logic                row_end_reg;

    logic                req_take;
    logic                s1_advance;
    logic                s1_emit;
    logic                res_free;

    logic [15:0]          rgb_c;
    logic [7:0]           alpha_c;
    logic [WIDTH_W-1:0]   width_c;
    logic [ROW_W-1:0]     row_c;
    logic                 last_c;
    logic [ADDRESS_W-1:0] address_c;
    logic [WIDTH_W+ROW_W-1:0] product_c;

    assign res_free   = !res_valid_reg || !res_stall;
    assign s1_advance = s1_valid_reg && ((s1_func_reg != FUNC_PIXEL) || res_free);
    assign s1_emit    = s1_advance && (s1_func_reg == FUNC_PIXEL);
    assign req_stall  = s1_valid_reg && !s1_advance;
    assign req_take   = req_valid && !req_stall;

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            if (func == FUNC_LOAD_PALETTE
                && {1'b0, entry_index} < (INDEX_W+1)'(PALETTE_DEPTH))
            begin
                palette_mem[entry_index] <= {byte0, byte1, byte2};
            end
            if (func == FUNC_LOAD_TRANS
                && {1'b0, entry_index} < (INDEX_W+1)'(PALETTE_DEPTH))
            begin
                trans_mem[entry_index] <= byte3;
            end
            pal_data_reg   <= palette_mem[byte0];
            trans_data_reg <= trans_mem[byte0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_kind_reg   <= KIND_COLOR;
            trans_map_reg    <= 1'b0;
            image_width_reg  <= WIDTH_W'(1);
            trans_length_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_PIXEL_KIND:   pixel_kind_reg   <= cfg_data[2:0];
                CFG_TRANS_MAP:    trans_map_reg    <= cfg_data[0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_TRANS_LENGTH: trans_length_reg <= cfg_data[TLEN_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_func_reg  <= func;
            s1_byte0_reg <= byte0;
            s1_byte1_reg <= byte1;
            s1_byte2_reg <= byte2;
            s1_byte3_reg <= byte3;
            s1_row_reg   <= row;
        end
    end

    always_comb
    begin
        logic [7:0] r8;
        logic [7:0] g8;
        logic [7:0] b8;
        if (pixel_kind_reg == KIND_COLOR || pixel_kind_reg == (KIND_COLOR | KIND_ALPHA))
        begin
            r8 = s1_byte0_reg;
            g8 = s1_byte1_reg;
            b8 = s1_byte2_reg;
            alpha_c = ((pixel_kind_reg & KIND_ALPHA) != 3'd0 || trans_map_reg)
                      ? s1_byte3_reg : OPAQUE;
        end
        else
        begin
            r8 = pal_data_reg[23:16];
            g8 = pal_data_reg[15:8];
            b8 = pal_data_reg[7:0];
            if ((pixel_kind_reg & (KIND_ALPHA | KIND_COLOR)) == KIND_ALPHA)
            begin
                alpha_c = s1_byte1_reg;
            end
            else if (trans_map_reg)
            begin
                if ((pixel_kind_reg & KIND_COLOR) == 3'd0)
                begin
                    alpha_c = s1_byte1_reg;
                end
                else
                begin
                    alpha_c = ({1'b0, s1_byte0_reg} < trans_length_reg)
                              ? trans_data_reg : OPAQUE;
                end
            end
            else
            begin
                alpha_c = OPAQUE;
            end
        end
        rgb_c = {r8[7:3], g8[7:2], b8[7:3]};
    end

    always_comb
    begin
        if (image_width_reg == '0)
        begin
            width_c = WIDTH_W'(1);
        end
        else if (image_width_reg > WIDTH_W'(MAX_WIDTH))
        begin
            width_c = WIDTH_W'(MAX_WIDTH);
        end
        else
        begin
            width_c = image_width_reg;
        end

        if ({1'b0, s1_row_reg} > (ROW_W+1)'(MAX_HEIGHT - 1))
        begin
            row_c = ROW_W'(MAX_HEIGHT - 1);
        end
        else
        begin
            row_c = s1_row_reg;
        end

        last_c    = ({1'b0, column_count_reg} + WIDTH_W'(1)) >= width_c;
        product_c = row_c * width_c;
        address_c = ADDRESS_W'(product_c + (WIDTH_W+ROW_W)'(column_count_reg));

        column_count_next = column_count_reg;
        alpha_flag_next   = alpha_flag_reg;
        if (s1_advance && s1_func_reg == FUNC_START_IMAGE)
        begin
            column_count_next = '0;
            alpha_flag_next   = 1'b0;
        end
        else if (s1_emit)
        begin
            column_count_next = last_c ? '0 : column_count_reg + COLUMN_W'(1);
            alpha_flag_next   = alpha_flag_reg || (alpha_c != OPAQUE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            alpha_flag_reg   <= 1'b0;
            res_valid_reg    <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            alpha_flag_reg   <= alpha_flag_next;
            if (s1_emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_emit)
        begin
            address_reg <= address_c;
            rgb_reg     <= rgb_c;
            alpha_reg   <= alpha_c;
            seen_reg    <= alpha_flag_next;
            row_end_reg <= last_c;
        end
    end

    assign res_valid     = res_valid_reg;
    assign pixel_address = address_reg;
    assign pixel_rgb565  = rgb_reg;
    assign pixel_alpha   = alpha_reg;
    assign alpha_seen    = seen_reg;
    assign row_end       = row_end_reg;

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && req_stall) |=> (s1_valid_reg && $stable(s1_byte0_reg)))
        else $error("A held request in the second stage was lost or changed.");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_func_reg == FUNC_START_IMAGE)
        |=> (column_count_reg == '0 && !alpha_flag_reg))
        else $error("Start image did not clear the column and alpha flag.");

    a_seen_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (alpha_reg == OPAQUE || seen_reg))
        else $error("A translucent pixel was sent without the alpha seen flag.");

endmodule
